### hdl/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types and constants of the sliding median filter.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int MAX_RADIUS = 4;
  localparam int SAMPLE_W   = 16;
  localparam int RAD_W      = 3;
  localparam int HIST_DEPTH = 2 * MAX_RADIUS + 1;
  localparam int IDX_W      = $clog2(HIST_DEPTH);
  localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
  // signed window offset, wide enough for 2*lim+1 and for negative offsets
  localparam int OFS_W      = CNT_W + 2;

  localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(2);

  typedef logic signed [SAMPLE_W-1:0] smp_word_t;

  // link from one sort cell to its right-hand neighbor
  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                valid;
    logic                gt;     // new value sorts before this cell
  } cell_link_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SORT,
    ST_EMIT
  } smf_state_t;

endpackage

### hdl/smf_sort_cell.sv
// ----------------------------------------------------------------------------
// smf_sort_cell
// One cell of the insertion sort row: holds one value, takes the new value
// or its left neighbor's value so that the row stays in ascending order.
// ----------------------------------------------------------------------------
module smf_sort_cell
  import smf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       clr,
  input  logic       ins,
  input  smp_word_t  din,
  input  cell_link_t left_link,
  output cell_link_t right_link
);

  logic [SAMPLE_W-1:0] val_r, val_nxt;
  logic                vld_r, vld_nxt;
  logic                own_gt;

  // clear acts as if every cell were empty
  assign own_gt = clr | ~vld_r | ($signed(val_r) > din);

  assign right_link.value = val_r;
  assign right_link.valid = vld_r & ~clr;
  assign right_link.gt    = own_gt;

  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r & ~(ins & clr);
    if (ins) begin
      priority if (left_link.gt) begin
        val_nxt = left_link.value;
        vld_nxt = left_link.valid;
      end else if (own_gt) begin
        val_nxt = din;
        vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

### hdl/smf_sort_chain.sv
// ----------------------------------------------------------------------------
// smf_sort_chain
// Row of sort cells; one value enters per cycle while ins is high, the row holds the window
// in ascending order after the last insert.
// ----------------------------------------------------------------------------
module smf_sort_chain
  import smf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      clr,
  input  logic      ins,
  input  smp_word_t din,
  output smp_word_t sorted [HIST_DEPTH]
);

  cell_link_t links [HIST_DEPTH+1];

  // left boundary: nothing ever sorts before it
  assign links[0] = '{value: '0, valid: 1'b0, gt: 1'b0};

  for (genvar i = 0; i < HIST_DEPTH; i++) begin : g_cell
    smf_sort_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .clr        (clr),
      .ins        (ins),
      .din        (din),
      .left_link  (links[i]),
      .right_link (links[i+1])
    );
    assign sorted[i] = smp_word_t'(links[i+1].value);
  end

endmodule

### hdl/sliding_median_filter.sv
// ----------------------------------------------------------------------------
// sliding_median_filter
// Running median over framed samples with mirrored frame edges.
// ----------------------------------------------------------------------------
// channel | ports                                   | direction
// in      | in_valid, in_stall, in_sample_in, in_frame_end   | sample in
// out     | out_valid, out_stall, out_median_out, out_last_out | median out
// cfg     | cfg_valid, cfg_ready, cfg_radius        | radius write
//
// Each median inserts the 2*radius+1 window values into the sort cell row,
// one per cycle, and then loads the output register. Input is stalled while
// a median is being formed. A frame-end sample yields up to radius+1 medians
// back to back. Reset is synchronous, active low, and sets radius to 2. A
// stalled output holds the sequencer in its emit step; input is taken again
// once the median sits in the output register.
// ----------------------------------------------------------------------------
module sliding_median_filter
  import smf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  smp_word_t        in_sample_in,
  input  logic             in_frame_end,
  output logic             out_valid,
  input  logic             out_stall,
  output smp_word_t        out_median_out,
  output logic             out_last_out,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [RAD_W-1:0] cfg_radius
);

  smf_state_t       state_r, state_nxt;
  smp_word_t        hist_r [HIST_DEPTH];
  logic [CNT_W-1:0] seen_r, seen_nxt;
  logic [RAD_W-1:0] radius_r;
  logic [RAD_W-1:0] rad_r, rad_nxt;
  logic [CNT_W-1:0] lim_r, lim_nxt;
  logic [RAD_W-1:0] ctr_r, ctr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             lastf_r, lastf_nxt;
  logic             out_valid_r, out_valid_nxt;
  smp_word_t        out_med_r;
  logic             out_last_r;

  logic             in_acc;
  logic             out_load;
  logic [RAD_W-1:0] rad_eff;
  logic [CNT_W-1:0] seen_inc;
  logic [CNT_W-1:0] lim_new;
  logic signed [OFS_W-1:0] ofs;
  logic signed [OFS_W-1:0] lim_s;
  logic signed [OFS_W-1:0] addr_s;
  logic [IDX_W-1:0] addr;
  logic             sort_clr;
  logic             sort_ins;
  smp_word_t        sort_din;
  smp_word_t        sorted [HIST_DEPTH];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
    end else if (cfg_valid && cfg_ready) begin
      radius_r <= cfg_radius;
    end
  end

  // clamp radius into 1..MAX_RADIUS
  always_comb begin
    rad_eff = radius_r;
    if (radius_r == '0) begin
      rad_eff = RAD_W'(1);
    end else if (radius_r > RAD_W'(MAX_RADIUS)) begin
      rad_eff = RAD_W'(MAX_RADIUS);
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid & ~in_stall;

  // history shift line, newest first
  always_ff @(posedge clk) begin
    if (in_acc) begin
      hist_r[0] <= in_sample_in;
      for (int i = 1; i < HIST_DEPTH; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  assign seen_inc = (seen_r < CNT_W'(HIST_DEPTH)) ? seen_r + CNT_W'(1) : seen_r;
  assign lim_new  = seen_inc - CNT_W'(1);

  // mirrored fetch address for the current window position
  assign ofs   = $signed(OFS_W'(ctr_r)) - $signed(OFS_W'(rad_r)) + $signed(OFS_W'(cnt_r));
  assign lim_s = $signed(OFS_W'(lim_r));
  always_comb begin
    addr_s = ofs;
    if (ofs < 0) begin
      addr_s = -ofs - OFS_W'(1);
      if (addr_s > lim_s) begin
        addr_s = lim_s;
      end
    end else if (ofs > lim_s) begin
      addr_s = (lim_s <<< 1) + OFS_W'(1) - ofs;
      if (addr_s < 0) begin
        addr_s = '0;
      end
    end
  end
  assign addr = addr_s[IDX_W-1:0];

  assign sort_din = hist_r[addr];
  assign sort_ins = (state_r == ST_SORT);
  assign sort_clr = (cnt_r == '0);

  smf_sort_chain u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (sort_clr),
    .ins    (sort_ins),
    .din    (sort_din),
    .sorted (sorted)
  );

  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    seen_nxt  = seen_r;
    rad_nxt   = rad_r;
    lim_nxt   = lim_r;
    ctr_nxt   = ctr_r;
    cnt_nxt   = cnt_r;
    lastf_nxt = lastf_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          rad_nxt   = rad_eff;
          lim_nxt   = lim_new;
          cnt_nxt   = '0;
          lastf_nxt = in_frame_end;
          if (in_frame_end) begin
            seen_nxt  = '0;
            ctr_nxt   = (CNT_W'(rad_eff) < lim_new) ? rad_eff : lim_new[RAD_W-1:0];
            state_nxt = ST_SORT;
          end else begin
            seen_nxt = seen_inc;
            ctr_nxt  = rad_eff;
            if (lim_new >= CNT_W'(rad_eff)) begin
              state_nxt = ST_SORT;
            end
          end
        end
      end
      ST_SORT: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == {rad_r, 1'b0}) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          cnt_nxt = '0;
          if (lastf_r && ctr_r != '0) begin
            ctr_nxt   = ctr_r - RAD_W'(1);
            state_nxt = ST_SORT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seen_r      <= '0;
      rad_r       <= RADIUS_RST;
      lim_r       <= '0;
      ctr_r       <= '0;
      cnt_r       <= '0;
      lastf_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seen_r      <= seen_nxt;
      rad_r       <= rad_nxt;
      lim_r       <= lim_nxt;
      ctr_r       <= ctr_nxt;
      cnt_r       <= cnt_nxt;
      lastf_r     <= lastf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the median until the transaction completes
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_med_r  <= sorted[{1'b0, rad_r}];
      out_last_r <= lastf_r && (ctr_r == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_median_out = out_med_r;
  assign out_last_out   = out_last_r;

endmodule

### test/tb_sliding_median_filter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sliding_median_filter
// Self-checking bench for the sliding median filter. A short table of
// directed frames runs first. Random frames follow under several radius
// settings, and both channels idle at random. Every median transaction is
// compared field by field against a mirrored-window model or typed row.
// ----------------------------------------------------------------------------
module tb_sliding_median_filter;
  import smf_pkg::*;

  localparam int TAIL_CYC    = 40;
  localparam int HOLD_CYC    = 300;
  localparam int PHASE_ITEMS = 44;
  localparam int DIR_ROWS    = 24;

  typedef struct packed {
    smp_word_t median;
    logic      last;
  } median_t;

  typedef struct packed {
    smp_word_t smp;
    logic      fe;
    logic      typed;  // want holds the median of every transaction of this row
    smp_word_t want;
  } stim_row_t;

  typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;
  typedef enum {SMP_FULL, SMP_NARROW, SMP_RAMP, SMP_EXTREME} smp_style_t;

  // radius 2 from reset applies to the whole table
  stim_row_t dir_tab [DIR_ROWS] = '{
    {16'sh7fff, 1'b1, 1'b1, 16'sh7fff},
    {16'sh8000, 1'b1, 1'b1, 16'sh8000},
    {16'sh0000, 1'b1, 1'b1, 16'sh0000},
    {16'sh8000, 1'b0, 1'b0, 16'sh0000},
    {16'sh7fff, 1'b1, 1'b0, 16'sh0000},
    {16'sh8000, 1'b0, 1'b1, 16'sh8000},
    {16'sh8000, 1'b0, 1'b1, 16'sh8000},
    {16'sh8000, 1'b0, 1'b1, 16'sh8000},
    {16'sh8000, 1'b0, 1'b1, 16'sh8000},
    {16'sh8000, 1'b0, 1'b1, 16'sh8000},
    {16'sh8000, 1'b1, 1'b1, 16'sh8000},
    {16'sh7fff, 1'b0, 1'b0, 16'sh0000},
    {16'sh8000, 1'b0, 1'b0, 16'sh0000},
    {16'sh7fff, 1'b0, 1'b0, 16'sh0000},
    {16'sh8000, 1'b0, 1'b0, 16'sh0000},
    {16'sh7fff, 1'b0, 1'b0, 16'sh0000},
    {16'sh8000, 1'b0, 1'b0, 16'sh0000},
    {16'sh7fff, 1'b1, 1'b0, 16'sh0000},
    {16'sh5555, 1'b0, 1'b0, 16'sh0000},
    {16'shaaaa, 1'b1, 1'b0, 16'sh0000},
    {16'sh0001, 1'b0, 1'b0, 16'sh0000},
    {16'shfffe, 1'b0, 1'b0, 16'sh0000},
    {16'sh1234, 1'b0, 1'b0, 16'sh0000},
    {16'sh8001, 1'b1, 1'b0, 16'sh0000}
  };

  logic [RAD_W-1:0] rad_plan [10] = '{3'd1, 3'd4, 3'd3, 3'd0, 3'd7,
                                      3'd5, 3'd6, 3'd2, 3'd4, 3'd1};

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  smp_word_t        in_sample_in;
  logic             in_frame_end;
  logic             out_valid;
  logic             out_stall;
  smp_word_t        out_median_out;
  logic             out_last_out;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [RAD_W-1:0] cfg_radius;

  // model state
  smp_word_t        hist_line [HIST_DEPTH];
  int               frame_fill;
  logic [RAD_W-1:0] radius_reg;
  median_t          median_q [$];

  int err_cnt;
  int hold_reqs;
  int burst_left;

  sliding_median_filter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .in_frame_end   (in_frame_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_median_out (out_median_out),
    .out_last_out   (out_last_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_radius     (cfg_radius)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    err_cnt++;
    $display("%0t ns: %s", $time, what);
  endtask

  // Median of the mirrored window centered c samples before the newest one;
  // lim is the offset of the first sample of the frame.
  function automatic smp_word_t window_median(input int c, input int lim,
                                              input int r);
    smp_word_t win [HIST_DEPTH];
    smp_word_t v;
    int n, i, a;
    n = 0;
    for (int o = c - r; o <= c + r; o++) begin
      a = o;
      if (o < 0) begin
        a = -o - 1;
        if (a > lim) a = lim;
      end else if (o > lim) begin
        a = 2 * lim + 1 - o;
        if (a < 0) a = 0;
      end
      if (a < 0) a = 0;
      if (a > HIST_DEPTH - 1) a = HIST_DEPTH - 1;
      v = hist_line[a];
      i = n;
      while (i > 0 && win[i-1] > v) begin
        win[i] = win[i-1];
        i--;
      end
      win[i] = v;
      n++;
    end
    return win[r];
  endfunction

  function automatic void predict_medians(input smp_word_t s, input logic fe,
                                          ref median_t res [$]);
    int r, lim, c;
    median_t m;
    r = int'(radius_reg);
    if (r < 1) r = 1;
    if (r > MAX_RADIUS) r = MAX_RADIUS;
    for (int i = HIST_DEPTH - 1; i > 0; i--) hist_line[i] = hist_line[i-1];
    hist_line[0] = s;
    if (frame_fill < HIST_DEPTH) frame_fill++;
    lim = frame_fill - 1;
    res.delete();
    if (fe) begin
      // flush every pending position of the frame
      c = (r < lim) ? r : lim;
      while (c >= 0) begin
        m.median = window_median(c, lim, r);
        m.last   = (c == 0);
        res.push_back(m);
        c--;
      end
      frame_fill = 0;
    end else if (lim >= r) begin
      m.median = window_median(r, lim, r);
      m.last   = 1'b0;
      res.push_back(m);
    end
  endfunction

  task automatic idle_cycles(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_sample(input smp_word_t s, input logic fe, input logic typed,
                             input smp_word_t want);
    median_t res [$];
    @(negedge clk);
    in_valid     <= 1'b1;
    in_sample_in <= s;
    in_frame_end <= fe;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_medians(s, fe, res);
    foreach (res[i]) begin
      if (typed) res[i].median = want;
      median_q.push_back(res[i]);
    end
    // end the burst with a random gap, or run straight into the next one
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
    end
  endtask

  task automatic wait_drain();
    idle_cycles(1);
    while (median_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
  endtask

  task automatic write_radius(input logic [RAD_W-1:0] r);
    @(negedge clk);
    cfg_valid  <= 1'b1;
    cfg_radius <= r;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    radius_reg = r;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: stall pattern of its own, plus long holds on request
  initial begin
    rx_mode_t rx_mode;
    int run, hold_seen, hold_left;
    out_stall = 1'b0;
    rx_mode   = RX_FREE;
    run       = 0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYC;
      end
      if (run == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        run     = $urandom_range(16, 96);
      end
      run--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (rx_mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
          default:  out_stall <= ((run % 7) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    median_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (median_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected median %0d last %0b",
                                out_median_out, out_last_out));
      end else begin
        want = median_q.pop_front();
        if (out_median_out !== want.median)
          flag_mismatch($sformatf("median %0d, want %0d", out_median_out, want.median));
        if (out_last_out !== want.last)
          flag_mismatch($sformatf("last %0b, want %0b", out_last_out, want.last));
      end
    end
  end

  initial begin
    smp_style_t style;
    smp_word_t  s, ramp_step;
    int         sent, flen;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample_in = '0;
    in_frame_end = 1'b0;
    cfg_valid    = 1'b0;
    cfg_radius   = '0;
    foreach (hist_line[i]) hist_line[i] = '0;
    frame_fill = 0;
    radius_reg = RADIUS_RST;
    err_cnt    = 0;
    hold_reqs  = 0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i])
      send_sample(dir_tab[i].smp, dir_tab[i].fe, dir_tab[i].typed, dir_tab[i].want);

    // a phase may stop mid-frame, so the new radius then lands inside a frame
    foreach (rad_plan[p]) begin
      wait_drain();
      write_radius(rad_plan[p]);
      if (p == 2) hold_reqs++;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0, 1:    flen = $urandom_range(1, 3);
          2:       flen = $urandom_range(13, 30);
          default: flen = $urandom_range(4, 12);
        endcase
        style     = smp_style_t'($urandom_range(0, 3));
        ramp_step = smp_word_t'($urandom_range(0, 2000)) - 16'sd1000;
        s         = smp_word_t'($urandom);
        for (int k = 0; k < flen && sent < PHASE_ITEMS; k++) begin
          case (style)
            SMP_FULL:   s = smp_word_t'($urandom);
            SMP_NARROW: s = smp_word_t'($urandom_range(0, 6)) - 16'sd3;
            SMP_RAMP:   s = s + ramp_step;
            default: begin
              case ($urandom_range(0, 2))
                0:       s = 16'sh7fff;
                1:       s = 16'sh8000;
                default: s = 16'sh0000;
              endcase
            end
          endcase
          send_sample(s, k == flen - 1, 1'b0, '0);
          sent++;
          // hold the sender until every pending median is out
          if (p == 5 && sent == PHASE_ITEMS / 2) wait_drain();
        end
      end
    end

    wait_drain();
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sliding_median_filter.f
hdl/smf_pkg.sv
hdl/smf_sort_cell.sv
hdl/smf_sort_chain.sv
hdl/sliding_median_filter.sv
test/tb_sliding_median_filter.sv
